### rtl/mlex_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlex_pkg
// Shared types and constants for the message language lexer: lexer modes,
// token kinds, result beats and the queue record between front and back.
// ----------------------------------------------------------------------------
package mlex_pkg;

  // width of the running byte position
  localparam int OFFSET_BITS = 32;
  localparam int POS_W       = OFFSET_BITS;
  localparam int LEN_W       = OFFSET_BITS + 1;

  // result queue depth
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_WORD    = 3'd1,
    MODE_STRING  = 3'd2,
    MODE_SLASH   = 3'd3,
    MODE_COMMENT = 3'd4,
    MODE_SKIP    = 3'd5,
    MODE_BROKEN  = 3'd6,
    MODE_HALTED  = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    KIND_WORD    = 3'd0,
    KIND_STRING  = 3'd1,
    KIND_COMMENT = 3'd2,
    KIND_OPEN    = 3'd3,
    KIND_CLOSE   = 3'd4,
    KIND_UNTERM  = 3'd5,
    KIND_NEWLINE = 3'd6,
    KIND_UNREC   = 3'd7
  } kind_t;

  // one token report, offsets already saturated to 32 bits
  typedef struct packed {
    kind_t       kind;
    logic [31:0] start;
    logic [31:0] len;
  } res_t;

  // all results caused by one input byte
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } rec_t;

endpackage

### rtl/mlex_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlex_front
// Lexer state machine: takes one source byte per cycle while the queue is not
// full, updates the mode and offsets, and pushes the one or two token reports it causes as one record.
// ----------------------------------------------------------------------------
module mlex_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [7:0] source_byte
  input  logic          in_tlast,   // end_of_file
  input  logic          q_full,
  output logic          push,
  output mlex_pkg::rec_t push_rec
);
  import mlex_pkg::*;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_OPEN   = 8'h7B;
  localparam logic [7:0] CH_CLOSE  = 8'h7D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam int         SAT_W     = (LEN_W > 32) ? LEN_W : 32;

  // outcome of a byte seen between tokens
  typedef struct packed {
    mode_t mode;
    logic  set_ts;
    logic  set_qs;
    logic  emit;
    kind_t kind;
    logic  len_one;
    logic  luw;
  } idle_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_word_byte(input logic [7:0] b);
    return is_letter(b) || ((b >= 8'h30) && (b <= 8'h39)) || (b == CH_UNDER);
  endfunction

  function automatic logic [31:0] sat32(input logic [LEN_W-1:0] v);
    logic [SAT_W-1:0] e;
    e = SAT_W'(v);
    return (e > SAT_W'(33'h0_FFFF_FFFF)) ? 32'hFFFF_FFFF : e[31:0];
  endfunction

  function automatic idle_t idle_byte(input logic [7:0] b, input logic eof,
                                      input logic luw_in);
    idle_t r;
    r.mode    = MODE_IDLE;
    r.set_ts  = 1'b1;
    r.set_qs  = 1'b0;
    r.emit    = 1'b0;
    r.kind    = KIND_UNREC;
    r.len_one = 1'b0;
    r.luw     = luw_in;
    if (is_space(b)) begin
      r.set_ts = 1'b0;
    end else if ((b == CH_DQUOTE) || (b == CH_SQUOTE)) begin
      r.mode   = MODE_STRING;
      r.set_qs = 1'b1;
    end else if (is_letter(b)) begin
      r.mode = MODE_WORD;
      if (eof) begin
        r.emit    = 1'b1;
        r.kind    = KIND_WORD;
        r.len_one = 1'b1;
        r.luw     = 1'b0;
      end
    end else if (b == CH_SLASH) begin
      r.mode = MODE_SLASH;
      if (eof) begin
        r.emit = !luw_in;
        r.luw  = 1'b1;
      end
    end else if ((b == CH_OPEN) || (b == CH_CLOSE)) begin
      r.emit    = 1'b1;
      r.kind    = (b == CH_OPEN) ? KIND_OPEN : KIND_CLOSE;
      r.len_one = 1'b1;
      r.luw     = 1'b0;
    end else begin
      r.mode = MODE_SKIP;
      r.emit = !luw_in;
      r.luw  = 1'b1;
    end
    return r;
  endfunction

  mode_t            mode_r, mode_nxt;
  logic             qs_r, qs_nxt;
  logic [POS_W-1:0] ts_r, ts_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             luw_r, luw_nxt;

  logic             accept;
  logic [7:0]       b;
  logic             eof;
  logic [7:0]       quote;
  logic             word_b;
  idle_t            idl;
  logic             use_idle;
  logic             luw_pre;
  logic             f_a, f_b, f_c;
  kind_t            kind_a;
  logic             inc_a;
  logic             zero_a;
  logic [LEN_W-1:0] len_a;
  res_t             res_a, res_b, res_c;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign eof       = in_tlast;
  assign quote     = qs_r ? CH_SQUOTE : CH_DQUOTE;
  assign word_b    = is_word_byte(b);
  // a word ends before the idle handling of its ending byte
  assign luw_pre   = (mode_r == MODE_WORD) ? 1'b0 : luw_r;
  assign idl       = idle_byte(b, eof, luw_pre);

  // next state and the report from the current mode
  always_comb begin
    mode_nxt = mode_r;
    qs_nxt   = qs_r;
    ts_nxt   = ts_r;
    luw_nxt  = luw_r;
    use_idle = 1'b0;
    f_a      = 1'b0;
    kind_a   = KIND_WORD;
    inc_a    = 1'b0;
    zero_a   = 1'b0;
    case (mode_r)
      MODE_IDLE: begin
        use_idle = 1'b1;
      end
      MODE_WORD: begin
        if (word_b) begin
          if (eof) begin
            f_a     = 1'b1;
            inc_a   = 1'b1;
            luw_nxt = 1'b0;
          end
        end else begin
          f_a      = 1'b1;
          luw_nxt  = 1'b0;
          use_idle = 1'b1;
        end
      end
      MODE_STRING: begin
        if (b == quote) begin
          f_a      = 1'b1;
          kind_a   = KIND_STRING;
          inc_a    = 1'b1;
          luw_nxt  = 1'b0;
          mode_nxt = MODE_IDLE;
        end else if (b == CH_LF) begin
          mode_nxt = MODE_BROKEN;
        end
      end
      MODE_BROKEN: begin
        if (b == quote) begin
          f_a      = 1'b1;
          kind_a   = KIND_NEWLINE;
          zero_a   = 1'b1;
          mode_nxt = MODE_HALTED;
        end
      end
      MODE_SLASH: begin
        if (b == CH_SLASH) begin
          mode_nxt = MODE_COMMENT;
          if (eof) begin
            f_a     = 1'b1;
            kind_a  = KIND_COMMENT;
            inc_a   = 1'b1;
            luw_nxt = 1'b0;
          end
        end else begin
          f_a      = !luw_r;
          kind_a   = KIND_UNREC;
          zero_a   = 1'b1;
          luw_nxt  = 1'b1;
          mode_nxt = (b == CH_LF) ? MODE_IDLE : MODE_SKIP;
        end
      end
      MODE_COMMENT: begin
        if (b == CH_LF) begin
          f_a      = 1'b1;
          kind_a   = KIND_COMMENT;
          luw_nxt  = 1'b0;
          mode_nxt = MODE_IDLE;
        end else if (eof) begin
          f_a     = 1'b1;
          kind_a  = KIND_COMMENT;
          inc_a   = 1'b1;
          luw_nxt = 1'b0;
        end
      end
      MODE_SKIP: begin
        if (b == CH_LF) begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_HALTED: begin
        mode_nxt = MODE_HALTED;
      end
      default: begin
        mode_nxt = mode_r;
      end
    endcase

    // byte handled as a token start
    if (use_idle) begin
      mode_nxt = idl.mode;
      luw_nxt  = idl.luw;
      if (idl.set_ts) begin
        ts_nxt = pos_r;
      end
      if (idl.set_qs) begin
        qs_nxt = (b == CH_SQUOTE);
      end
    end
  end

  assign f_b = use_idle && idl.emit;
  assign f_c = eof && ((mode_nxt == MODE_STRING) || (mode_nxt == MODE_BROKEN));

  // token length from its start, saturated on the way out
  assign len_a = {1'b0, pos_r} - {1'b0, ts_r} + LEN_W'(inc_a);

  assign res_a.kind  = kind_a;
  assign res_a.start = sat32({1'b0, ts_r});
  assign res_a.len   = zero_a ? 32'd0 : sat32(len_a);

  assign res_b.kind  = idl.kind;
  assign res_b.start = sat32({1'b0, pos_r});
  assign res_b.len   = idl.len_one ? 32'd1 : 32'd0;

  assign res_c.kind  = KIND_UNTERM;
  assign res_c.start = sat32({1'b0, ts_nxt});
  assign res_c.len   = 32'd0;

  // pack the reports in order into one record
  always_comb begin
    push_rec.r0  = f_a ? res_a : (f_b ? res_b : res_c);
    push_rec.r1  = (f_a && f_b) ? res_b : res_c;
    push_rec.two = (f_a && f_b) || ((f_a || f_b) && f_c);
  end

  assign push = accept && (f_a || f_b || f_c);

  // lexer state registers; end of file returns everything to reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      qs_r   <= 1'b0;
      ts_r   <= '0;
      pos_r  <= '0;
      luw_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= eof ? MODE_IDLE : mode_nxt;
      qs_r   <= eof ? 1'b0 : qs_nxt;
      ts_r   <= eof ? '0 : ts_nxt;
      pos_r  <= pos_nxt;
      luw_r  <= eof ? 1'b0 : luw_nxt;
    end
  end

  // saturating byte position
  always_comb begin
    if (eof) begin
      pos_nxt = '0;
    end else if (pos_r != {POS_W{1'b1}}) begin
      pos_nxt = pos_r + POS_W'(1);
    end else begin
      pos_nxt = pos_r;
    end
  end

endmodule

### rtl/mlex_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlex_queue
// Short first-in first-out queue of result records between the lexer front
// and the output back end.
// ----------------------------------------------------------------------------
module mlex_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mlex_pkg::rec_t push_rec,
  output logic           full,
  input  logic           pop,
  output mlex_pkg::rec_t head_rec,
  output logic           empty
);
  import mlex_pkg::*;

  rec_t              store_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_rec = store_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // record storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

### rtl/mlex_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlex_back
// Output back end: splits each queued record into one or two result beats
// and holds them in an output register until taken.
// ----------------------------------------------------------------------------
module mlex_back (
  input  logic           clk,
  input  logic           rst_n,
  input  mlex_pkg::rec_t head_rec,
  input  logic           empty,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [63:0]    out_tdata,   // [31:0] start_offset, [63:32] token_length
  output logic [2:0]     out_tuser,   // [2:0] token_kind
  output logic           out_tlast    // last_of_run
);
  import mlex_pkg::*;

  logic  valid_r, valid_nxt;
  logic  sel_r, sel_nxt;
  res_t  res_r;
  logic  last_r;
  logic  load;
  logic  is_last;
  res_t  slot;

  assign load    = !empty && (!valid_r || out_tready);
  assign slot    = sel_r ? head_rec.r1 : head_rec.r0;
  assign is_last = sel_r || !head_rec.two;
  assign pop     = load && is_last;

  // beat selection within a record
  always_comb begin
    valid_nxt = valid_r;
    sel_nxt   = sel_r;
    if (load) begin
      valid_nxt = 1'b1;
      sel_nxt   = !is_last;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= slot;
      last_r <= is_last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.len, res_r.start};
  assign out_tuser  = res_r.kind;
  assign out_tlast  = last_r;

endmodule

### rtl/message_language_lexer_unit.sv
`timescale 1ns / 1ps
// Path: a result beat passes through the result queue, then the output register.
// Throughput: one byte per cycle while the queue is not full; the output gives one
//   result beat per cycle while taken, so a byte with two results gives two beats (queue absorbs).
// Reset: synchronous rst_n returns the lexer to idle at offset 0 and empties
//   the result queue; no clearing pass.
// ----------------------------------------------------------------------------
// message_language_lexer_unit
// Streaming lexer for a small message language: words, strings, line
// comments and braces, with string and unrecognised-character errors.
// ----------------------------------------------------------------------------
module message_language_lexer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] source_byte
  input  logic        in_tlast,    // end_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [31:0] start_offset, [63:32] token_length
  output logic [2:0]  out_tuser,   // [2:0] token_kind
  output logic        out_tlast    // last_of_run
);
  import mlex_pkg::*;

  logic push;
  rec_t push_rec;
  logic q_full;
  logic q_empty;
  logic pop;
  rec_t head_rec;

  mlex_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_rec  (push_rec)
  );

  mlex_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .head_rec (head_rec),
    .empty    (q_empty)
  );

  mlex_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_rec   (head_rec),
    .empty      (q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream test of the message language lexer: a short hand-built byte table,
// then random source files made of well-formed tokens mixed with noise,
// broken strings and cut-off tails. Every result beat is checked against the
// table's typed rows or a lexer model kept in the bench, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import mlex_pkg::*;

  // source characters the lexer treats specially
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_USCORE  = 8'h5F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  localparam logic [63:0] POS_LIMIT   = (64'd1 << OFFSET_BITS) - 64'd1;
  localparam int          RAND_BYTES  = 1750;
  localparam int          HOLD_CYCLES = 80;
  localparam int          IDLE_LIMIT  = 2000;
  localparam int          DRAIN_WAIT  = 10;

  typedef struct {
    kind_t       kind;
    logic [31:0] start;
    logic [31:0] len;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        eof;
    logic        typed;
    kind_t       kind;
    logic [31:0] start;
    logic [31:0] len;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  // lexer model state
  mode_t       lx_mode;
  logic        lx_single;
  logic [63:0] lx_start;
  logic [63:0] lx_pos;
  logic        lx_unrec_seen;

  token_t      token_q[$];
  token_t      step_q[$];
  logic [7:0]  src_q[$];

  int          mismatch_count = 0;
  int          bytes_sent = 0;
  int          files_sent = 0;
  int          reports_seen = 0;
  int          kind_seen[8];
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  bit          burst_mode = 1'b0;

  // hand-built files: typed rows carry the one report they must give
  row_t dir_rows [25] = '{
    '{8'h7B,      1'b0, 1'b1, KIND_OPEN,    32'd0,  32'd1},
    '{8'h7D,      1'b0, 1'b1, KIND_CLOSE,   32'd1,  32'd1},
    '{8'h5A,      1'b0, 1'b0, KIND_WORD,    32'd0,  32'd0},
    '{8'h39,      1'b0, 1'b0, KIND_WORD,    32'd0,  32'd0},
    '{8'h5F,      1'b0, 1'b0, KIND_WORD,    32'd0,  32'd0},
    '{8'h7B,      1'b0, 1'b0, KIND_WORD,    32'd0,  32'd0},
    '{8'h22,      1'b0, 1'b0, KIND_WORD,    32'd0,  32'd0},
    '{8'h71,      1'b0, 1'b0, KIND_WORD,    32'd0,  32'd0},
    '{8'h22,      1'b0, 1'b0, KIND_WORD,    32'd0,  32'd0},
    '{8'h2F,      1'b0, 1'b0, KIND_WORD,    32'd0,  32'd0},
    '{8'h2F,      1'b0, 1'b0, KIND_WORD,    32'd0,  32'd0},
    '{8'hFF,      1'b0, 1'b0, KIND_WORD,    32'd0,  32'd0},
    '{8'h0A,      1'b0, 1'b0, KIND_WORD,    32'd0,  32'd0},
    '{8'h2F,      1'b0, 1'b0, KIND_WORD,    32'd0,  32'd0},
    '{8'h78,      1'b0, 1'b1, KIND_UNREC,   32'd13, 32'd0},
    '{8'h0A,      1'b0, 1'b0, KIND_WORD,    32'd0,  32'd0},
    '{8'h80,      1'b0, 1'b0, KIND_WORD,    32'd0,  32'd0},
    '{8'h09,      1'b1, 1'b0, KIND_WORD,    32'd0,  32'd0},
    '{8'h27,      1'b0, 1'b0, KIND_WORD,    32'd0,  32'd0},
    '{8'h0A,      1'b0, 1'b0, KIND_WORD,    32'd0,  32'd0},
    '{8'h22,      1'b0, 1'b0, KIND_WORD,    32'd0,  32'd0},
    '{8'h27,      1'b0, 1'b1, KIND_NEWLINE, 32'd0,  32'd0},
    '{8'h61,      1'b1, 1'b0, KIND_WORD,    32'd0,  32'd0},
    '{8'h22,      1'b0, 1'b0, KIND_WORD,    32'd0,  32'd0},
    '{8'h61,      1'b1, 1'b1, KIND_UNTERM,  32'd0,  32'd0}
  };

  message_language_lexer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- lexer model

  function automatic logic is_letter(logic [7:0] b);
    return (b >= CH_LOWER_A && b <= CH_LOWER_Z) || (b >= CH_UPPER_A && b <= CH_UPPER_Z);
  endfunction

  task automatic lx_reset();
    lx_mode       = MODE_IDLE;
    lx_single     = 1'b0;
    lx_start      = '0;
    lx_pos        = '0;
    lx_unrec_seen = 1'b0;
  endtask

  // one report, offsets and lengths clipped to 32 bits
  task automatic note(kind_t k, logic [63:0] s, logic [63:0] l);
    token_t t;
    t.kind  = k;
    t.start = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    t.len   = (l > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : l[31:0];
    t.last  = 1'b0;
    step_q.insert(step_q.size(), t);
  endtask

  // runs of unrecognised lines report only the first
  task automatic flag_unrec(logic [63:0] at);
    if (!lx_unrec_seen) note(KIND_UNREC, at, 64'd0);
    lx_unrec_seen = 1'b1;
  endtask

  task automatic idle_byte(logic [7:0] b, logic [63:0] p, logic eof);
    if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) return;
    lx_start = p;
    if (b == CH_DQUOTE || b == CH_SQUOTE) begin
      lx_mode   = MODE_STRING;
      lx_single = (b == CH_SQUOTE);
    end else if (is_letter(b)) begin
      lx_mode = MODE_WORD;
      if (eof) begin
        note(KIND_WORD, p, 64'd1);
        lx_unrec_seen = 1'b0;
      end
    end else if (b == CH_SLASH) begin
      lx_mode = MODE_SLASH;
      if (eof) flag_unrec(p);
    end else if (b == CH_LBRACE || b == CH_RBRACE) begin
      note((b == CH_LBRACE) ? KIND_OPEN : KIND_CLOSE, p, 64'd1);
      lx_unrec_seen = 1'b0;
    end else begin
      flag_unrec(p);
      lx_mode = MODE_SKIP;
    end
  endtask

  // reports caused by one byte land in step_q, the last one marked
  task automatic lex_byte(logic [7:0] b, logic eof);
    logic [63:0] p;
    logic [7:0]  quote;
    p = lx_pos;
    quote = lx_single ? CH_SQUOTE : CH_DQUOTE;
    step_q.delete();
    case (lx_mode)
      MODE_IDLE: begin
        idle_byte(b, p, eof);
      end
      MODE_WORD: begin
        if (is_letter(b) || (b >= CH_ZERO && b <= CH_NINE) || b == CH_USCORE) begin
          if (eof) begin
            note(KIND_WORD, lx_start, p - lx_start + 64'd1);
            lx_unrec_seen = 1'b0;
          end
        end else begin
          note(KIND_WORD, lx_start, p - lx_start);
          lx_unrec_seen = 1'b0;
          lx_mode = MODE_IDLE;
          idle_byte(b, p, eof);
        end
      end
      MODE_STRING: begin
        if (b == quote) begin
          note(KIND_STRING, lx_start, p - lx_start + 64'd1);
          lx_unrec_seen = 1'b0;
          lx_mode = MODE_IDLE;
        end else if (b == CH_LF) begin
          lx_mode = MODE_BROKEN;
        end
      end
      MODE_BROKEN: begin
        if (b == quote) begin
          note(KIND_NEWLINE, lx_start, 64'd0);
          lx_mode = MODE_HALTED;
        end
      end
      MODE_SLASH: begin
        if (b == CH_SLASH) begin
          lx_mode = MODE_COMMENT;
          if (eof) begin
            note(KIND_COMMENT, lx_start, p - lx_start + 64'd1);
            lx_unrec_seen = 1'b0;
          end
        end else begin
          flag_unrec(lx_start);
          lx_mode = (b == CH_LF) ? MODE_IDLE : MODE_SKIP;
        end
      end
      MODE_COMMENT: begin
        if (b == CH_LF) begin
          note(KIND_COMMENT, lx_start, p - lx_start);
          lx_unrec_seen = 1'b0;
          lx_mode = MODE_IDLE;
        end else if (eof) begin
          note(KIND_COMMENT, lx_start, p - lx_start + 64'd1);
          lx_unrec_seen = 1'b0;
        end
      end
      MODE_SKIP: begin
        if (b == CH_LF) lx_mode = MODE_IDLE;
      end
      default: begin
      end
    endcase
    // an open string at end of file
    if (eof && (lx_mode == MODE_STRING || lx_mode == MODE_BROKEN))
      note(KIND_UNTERM, lx_start, 64'd0);
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    if (eof) lx_reset();
    else if (lx_pos < POS_LIMIT) lx_pos = lx_pos + 64'd1;
  endtask

  // ---------------------------------------------------------------- input side

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || (hold_req && !hold_done) || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // offer one source beat, then predict its reports once it is taken
  task automatic send_byte(logic [7:0] b, logic eof, logic typed, kind_t k,
                           logic [31:0] s, logic [31:0] l);
    int     g;
    token_t t;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eof;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if ($urandom_range(0, 99) == 0) burst_mode = !burst_mode;
    lex_byte(b, eof);
    if (typed) begin
      t.kind  = k;
      t.start = s;
      t.len   = l;
      t.last  = 1'b1;
      token_q.insert(token_q.size(), t);
    end else begin
      foreach (step_q[i]) token_q.insert(token_q.size(), step_q[i]);
    end
    if (eof) files_sent++;
  endtask

  function automatic logic [7:0] ws_byte();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  // random byte that is neither of two given bytes
  function automatic logic [7:0] pick_other(logic [7:0] a, logic [7:0] c);
    logic [7:0] x;
    do x = 8'($urandom_range(0, 255)); while (x == a || x == c);
    return x;
  endfunction

  // append one byte to the file being built
  task automatic put_src(logic [7:0] v);
    src_q.insert(src_q.size(), v);
  endtask

  // one random source file into src_q, mostly well-formed tokens
  task automatic build_file();
    int         pieces;
    int         r;
    int         n;
    logic [7:0] q;
    src_q.delete();
    pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 10);
    repeat (pieces) begin
      r = $urandom_range(0, 99);
      q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
      if (r < 22) begin
        // word
        put_src(8'($urandom_range(0, 1) ? CH_LOWER_A + $urandom_range(0, 25)
                                        : CH_UPPER_A + $urandom_range(0, 25)));
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 3))
            0: put_src(8'(CH_LOWER_A + $urandom_range(0, 25)));
            1: put_src(8'(CH_UPPER_A + $urandom_range(0, 25)));
            2: put_src(8'(CH_ZERO + $urandom_range(0, 9)));
            default: put_src(CH_USCORE);
          endcase
        end
        if ($urandom_range(0, 3) != 0) put_src(ws_byte());
      end else if (r < 34) begin
        // closed string
        put_src(q);
        repeat ($urandom_range(0, 5)) put_src(pick_other(q, CH_LF));
        put_src(q);
      end else if (r < 44) begin
        // line comment
        put_src(CH_SLASH);
        put_src(CH_SLASH);
        repeat ($urandom_range(0, 6)) put_src(pick_other(CH_LF, CH_LF));
        put_src(CH_LF);
      end else if (r < 56) begin
        put_src($urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE);
      end else if (r < 70) begin
        repeat ($urandom_range(1, 3)) put_src(ws_byte());
      end else if (r < 80) begin
        put_src(8'($urandom_range(0, 255)));
      end else if (r < 86) begin
        // lone slash
        put_src(CH_SLASH);
        put_src($urandom_range(0, 1) ? CH_LF : pick_other(CH_SLASH, CH_SLASH));
      end else if (r < 92) begin
        // unrecognised line
        put_src($urandom_range(0, 1) ? CH_HASH : 8'(8'h80 + $urandom_range(0, 127)));
        repeat ($urandom_range(0, 4)) put_src(8'($urandom_range(0, 255)));
        put_src(CH_LF);
      end else begin
        // string broken by a newline, sometimes closed later
        put_src(q);
        repeat ($urandom_range(0, 3)) put_src(pick_other(q, CH_LF));
        put_src(CH_LF);
        repeat ($urandom_range(0, 3)) put_src(pick_other(q, q));
        if ($urandom_range(0, 1)) put_src(q);
        repeat ($urandom_range(0, 3)) put_src(8'($urandom_range(0, 255)));
      end
    end
    // cut-off tails and trailing whitespace
    if ($urandom_range(0, 3) == 0 && src_q.size() > 1) begin
      n = $urandom_range(1, 3);
      while (n > 0 && src_q.size() > 1) begin
        void'(src_q.pop_back());
        n--;
      end
    end
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) put_src(ws_byte());
  endtask

  // ---------------------------------------------------------------- output side

  // receiver stalls, with one long hold that fills the block
  initial begin
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_tready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 100)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
      if ($urandom_range(0, 2) != 0) begin
        out_tready <= 1'b0;
        if ($urandom_range(0, 19) == 0) repeat ($urandom_range(15, 40)) @(posedge clk);
        else repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

  // compare each result beat with the oldest predicted report
  always @(posedge clk) begin
    token_t want;
    if (rst_n && out_tvalid && out_tready) begin
      reports_seen++;
      kind_seen[out_tuser]++;
      if (token_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat kind %0d start %0d len %0d", $time,
                 out_tuser, out_tdata[31:0], out_tdata[63:32]);
      end else begin
        want = token_q.pop_front();
        if (out_tuser !== want.kind) begin
          mismatch_count++;
          $display("%0t: token_kind expected %0d actual %0d", $time, want.kind, out_tuser);
        end
        if (out_tdata[31:0] !== want.start) begin
          mismatch_count++;
          $display("%0t: start_offset expected %0d actual %0d", $time, want.start,
                   out_tdata[31:0]);
        end
        if (out_tdata[63:32] !== want.len) begin
          mismatch_count++;
          $display("%0t: token_length expected %0d actual %0d", $time, want.len,
                   out_tdata[63:32]);
        end
        if (out_tlast !== want.last) begin
          mismatch_count++;
          $display("%0t: last_of_run expected %0d actual %0d", $time, want.last, out_tlast);
        end
      end
    end
  end

  // watchdog on cycles in which neither side moves a beat
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no beat moved for %0d cycles, %0d reports outstanding", $time,
             IDLE_LIMIT, token_q.size());
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- main flow

  initial begin
    int rand_bytes;
    lx_reset();
    foreach (kind_seen[i]) kind_seen[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i])
      send_byte(dir_rows[i].b, dir_rows[i].eof, dir_rows[i].typed, dir_rows[i].kind,
                dir_rows[i].start, dir_rows[i].len);

    // random files
    rand_bytes = 0;
    while (rand_bytes < RAND_BYTES) begin
      build_file();
      foreach (src_q[i]) begin
        if (rand_bytes >= 400 && !hold_req) hold_req = 1'b1;
        send_byte(src_q[i], i == src_q.size() - 1, 1'b0, KIND_WORD, 32'd0, 32'd0);
        rand_bytes++;
      end
    end
    in_tvalid <= 1'b0;

    // drain
    while (token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d files, %0d source beats, %0d result beats, %0d mismatches",
             files_sent, bytes_sent, reports_seen, mismatch_count);
    $display("by kind word/str/cmt/open/close/unterm/newline/unrec: %0d %0d %0d %0d %0d %0d %0d %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5], kind_seen[6], kind_seen[7]);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
